/* src/round_robin_time_slice_dispatcher_unit_macros.svh */
// Assertion macros shared by the dispatcher RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ROUND_ROBIN_TIME_SLICE_DISPATCHER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICE_DISPATCHER_UNIT_MACROS_SVH

// Property checked every cycle outside reset.
`define RRD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rrd_pkg.sv */
// Package for the round-robin time-slice dispatcher: widths, codes, structs.
// No dependencies.
package rrd_pkg;

	localparam int unsigned ID_W    = 8;
	localparam int unsigned REM_W   = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SLICE_W = 8;
	localparam int unsigned IN_W    = 24;
	localparam int unsigned OUT_W   = 56;

	localparam logic [SLICE_W-1:0] TIME_SLICE_RESET = 8'd4;

	typedef enum logic {
		OP_ARRIVAL = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	typedef struct packed {
		logic             push;
		logic [ID_W-1:0]  push_id;
		logic [REM_W-1:0] push_rem;
		logic             pop;
	} queue_req_t;

	typedef struct packed {
		logic             empty;
		logic             full;
		logic [ID_W-1:0]  head_id;
		logic [REM_W-1:0] head_rem;
	} queue_stat_t;

endpackage

/* src/rrd_queue.sv */
// Ready queue: circular buffer memory with pointers and a registered head entry.
// Depends on rrd_pkg and the dispatcher macros header.
`include "round_robin_time_slice_dispatcher_unit_macros.svh"

module rrd_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrd_pkg::queue_req_t req,
	output rrd_pkg::queue_stat_t stat
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [rrd_pkg::ID_W-1:0]  id;
		logic [rrd_pkg::REM_W-1:0] rem;
	} entry_t;

	entry_t          mem [DEPTH];
	entry_t          head_data_q;
	entry_t          wr_data;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   head_nx;
	logic            full;
	logic            push_ok;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign push_ok = req.push && !(full && !req.pop);
	assign head_nx = req.pop ? nxt(head_q) : head_q;
	assign wr_data = '{id: req.push_id, rem: req.push_rem};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_nx;
			if (push_ok) begin
				tail_q <= nxt(tail_q);
			end
			case ({push_ok, req.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[tail_q] <= wr_data;
		end
	end

	// head entry, with bypass when the new head slot is written this cycle
	always_ff @(posedge clk) begin
		if (push_ok && (tail_q == head_nx)) begin
			head_data_q <= wr_data;
		end else begin
			head_data_q <= mem[head_nx];
		end
	end

	assign stat.empty    = (count_q == '0);
	assign stat.full     = full;
	assign stat.head_id  = head_data_q.id;
	assign stat.head_rem = head_data_q.rem;

	`RRD_ASSERT(a_count_max, clk, arst_n, count_q <= CW'(DEPTH), "queue count above depth")
	`RRD_ASSERT(a_pop_nonempty, clk, arst_n, !req.pop || (count_q != '0), "pop from empty queue")
	`RRD_ASSERT_NEXT(a_push_grows, clk, arst_n, push_ok && !req.pop, count_q == $past(count_q) + 1'b1, "push did not grow count")
	`RRD_ASSERT_NEXT(a_drop_holds, clk, arst_n, req.push && full && !req.pop, $stable(count_q) && $stable(tail_q), "dropped push changed queue")

endmodule

/* src/rrd_sched.sv */
// Dispatch control: input register, time and slice state, result register.
// Depends on rrd_pkg; drives the ready queue through queue_req_t.
module rrd_sched (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rrd_pkg::IN_W-1:0]    s_tdata,  // process_id, burst_length
	input  logic [0:0]                  s_tuser,  // opcode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rrd_pkg::OUT_W-1:0]   m_tdata,  // dispatched_id, start_time, run_length, overflow_seen
	input  logic [rrd_pkg::SLICE_W-1:0] time_slice,
	input  rrd_pkg::queue_stat_t        q_stat,
	output rrd_pkg::queue_req_t         q_req
);

	logic                          valid_s1;
	rrd_pkg::op_t                  op_s1;
	logic [rrd_pkg::ID_W-1:0]      id_s1;
	logic [rrd_pkg::REM_W-1:0]     burst_s1;

	logic [rrd_pkg::TIME_W-1:0]    cur_q;
	logic [rrd_pkg::TIME_W-1:0]    end_q;
	logic [rrd_pkg::ID_W-1:0]      pre_id_q;
	logic [rrd_pkg::REM_W-1:0]     pre_rem_q;
	logic                          ovf_q;

	logic                          m_valid_q;
	logic [rrd_pkg::OUT_W-1:0]     m_data_q;

	logic                          advance;
	logic                          is_tick;
	logic                          idle;
	logic                          dispatch;
	logic [rrd_pkg::SLICE_W-1:0]   slice;
	logic [rrd_pkg::SLICE_W-1:0]   run;
	logic [rrd_pkg::REM_W-1:0]     rem_left;
	logic [rrd_pkg::REM_W-1:0]     pre_rem_nx;
	logic [rrd_pkg::ID_W-1:0]      pre_id_nx;
	logic                          end_now;
	logic                          requeue;
	logic                          arrive_push;
	logic                          drop;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign is_tick  = (op_s1 == rrd_pkg::OP_TICK);
	assign idle     = (end_q == cur_q);
	assign dispatch = advance && is_tick && idle && !q_stat.empty;

	assign slice    = (time_slice == '0) ? rrd_pkg::SLICE_W'(1) : time_slice;
	assign run      = (q_stat.head_rem < {8'd0, slice}) ? q_stat.head_rem[7:0] : slice;
	assign rem_left = q_stat.head_rem - {8'd0, run};

	assign pre_rem_nx = dispatch ? rem_left : pre_rem_q;
	assign pre_id_nx  = dispatch ? q_stat.head_id : pre_id_q;

	// slice ends at the new time
	always_comb begin
		if (dispatch) begin
			end_now = (run == rrd_pkg::SLICE_W'(1));
		end else if (idle) begin
			end_now = 1'b1;
		end else begin
			end_now = (end_q == cur_q + 1'b1);
		end
	end

	assign requeue     = advance && is_tick && end_now && (pre_rem_nx != '0);
	assign arrive_push = advance && !is_tick && (burst_s1 != '0);
	assign drop        = (requeue || arrive_push) && q_stat.full && !dispatch;

	assign q_req.push     = requeue || arrive_push;
	assign q_req.push_id  = is_tick ? pre_id_nx : id_s1;
	assign q_req.push_rem = is_tick ? pre_rem_nx : burst_s1;
	assign q_req.pop      = dispatch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= rrd_pkg::op_t'(s_tuser[0]);
			id_s1    <= s_tdata[7:0];
			burst_s1 <= s_tdata[23:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			end_q     <= '0;
			pre_id_q  <= '0;
			pre_rem_q <= '0;
			ovf_q     <= 1'b0;
		end else if (advance) begin
			if (is_tick) begin
				cur_q <= cur_q + 1'b1;
				if (dispatch) begin
					end_q <= cur_q + {24'd0, run};
				end else if (idle) begin
					end_q <= cur_q + 1'b1;
				end
				if (requeue) begin
					pre_id_q  <= '0;
					pre_rem_q <= '0;
				end else begin
					pre_id_q  <= pre_id_nx;
					pre_rem_q <= pre_rem_nx;
				end
			end
			if (drop) begin
				ovf_q <= 1'b1;
			end else if (dispatch) begin
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (dispatch) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dispatch) begin
			m_data_q <= {7'd0, ovf_q, run, cur_q, q_stat.head_id};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

/* src/round_robin_time_slice_dispatcher_unit.sv */
// Round-robin time-slice dispatcher, top level.
// Path: a tick that dispatches passes the input register, then the result register.
// Throughput: one item per cycle, set by the single-pass dispatch stage and
// the one-write, one-read ready-queue memory; an item waits in the input
// register while an earlier result is held by m_tready.
// Reset: arst_n clears time, queue pointers and flags; time_slice returns to 4.
// Depends on rrd_pkg, rrd_queue and rrd_sched.
module round_robin_time_slice_dispatcher_unit #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rrd_pkg::IN_W-1:0]    s_tdata,  // [7:0] process_id, [23:8] burst_length
	input  logic [0:0]                  s_tuser,  // [0] opcode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rrd_pkg::OUT_W-1:0]   m_tdata,  // [7:0] dispatched_id, [39:8] start_time,
	                                              // [47:40] run_length, [48] overflow_seen
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rrd_pkg::SLICE_W-1:0] cfg_data  // time_slice
);

	logic [rrd_pkg::SLICE_W-1:0] time_slice_q;
	rrd_pkg::queue_req_t         q_req;
	rrd_pkg::queue_stat_t        q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= rrd_pkg::TIME_SLICE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			time_slice_q <= cfg_data;
		end
	end

	rrd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (q_req),
		.stat  (q_stat)
	);

	rrd_sched u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.time_slice(time_slice_q),
		.q_stat    (q_stat),
		.q_req     (q_req)
	);

endmodule

/* tb/sv/tb_round_robin_time_slice_dispatcher_unit.sv */
// Self-checking testbench for round_robin_time_slice_dispatcher_unit: a directed
// burst, then random arrival/tick streams under several time slices.
// Depends on rrd_pkg and the dispatcher RTL.
module tb_round_robin_time_slice_dispatcher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RQ_DEPTH     = 16;
	localparam int unsigned RANDOM_ITEMS = 900;
	localparam int unsigned MIN_DISPATCH = 60;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned QUIET_LIMIT  = 4000;

	typedef struct {
		rrd_pkg::op_t                  op;
		logic [rrd_pkg::ID_W-1:0]      pid;
		logic [rrd_pkg::REM_W-1:0]     burst;
	} sched_item_t;

	typedef struct {
		logic [rrd_pkg::ID_W-1:0]      id;
		logic [rrd_pkg::TIME_W-1:0]    start;
		logic [7:0]                    run;
		logic                          ovf;
	} dispatch_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [rrd_pkg::IN_W-1:0]      s_tdata   = '0;
	logic [0:0]                    s_tuser   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [rrd_pkg::OUT_W-1:0]     m_tdata;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [rrd_pkg::SLICE_W-1:0]   cfg_data  = '0;

	sched_item_t pending[$];
	sched_item_t cur_item;
	dispatch_t   dispatch_q[$];

	// dispatcher state as predicted
	logic [rrd_pkg::SLICE_W-1:0] slice_reg = rrd_pkg::TIME_SLICE_RESET;
	logic [rrd_pkg::ID_W-1:0]    rq_id  [RQ_DEPTH];
	logic [rrd_pkg::REM_W-1:0]   rq_rem [RQ_DEPTH];
	int unsigned                 rq_head = 0, rq_tail = 0, rq_count = 0;
	logic [rrd_pkg::TIME_W-1:0]  now_time = '0, slice_end = '0;
	logic [rrd_pkg::ID_W-1:0]    pre_id = '0;
	logic [rrd_pkg::REM_W-1:0]   pre_rem = '0;
	logic                        ovf_flag = 1'b0;

	int unsigned queued_items = 0, tick_items = 0, slice_writes = 0;
	int unsigned dispatches_predicted = 0, ovf_predicted = 0, results_seen = 0;
	int unsigned mismatches = 0, quiet_cycles = 0;
	int unsigned burst_left = 0, gap_left = 0;
	logic [15:0] stall_mask = '1;
	logic [5:0]  stall_pos = '0;

	round_robin_time_slice_dispatcher_unit #(
		.QUEUE_DEPTH(RQ_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic void ready_push(input logic [rrd_pkg::ID_W-1:0] id,
		input logic [rrd_pkg::REM_W-1:0] rem);
		if (rq_count >= RQ_DEPTH) begin
			ovf_flag = 1'b1;
			return;
		end
		rq_id[rq_tail]  = id;
		rq_rem[rq_tail] = rem;
		rq_tail = (rq_tail + 1 >= RQ_DEPTH) ? 0 : rq_tail + 1;
		rq_count++;
	endfunction

	function automatic void advance_dispatcher(input sched_item_t it);
		logic [rrd_pkg::REM_W-1:0] slice_units, head_rem, granted;
		logic [rrd_pkg::ID_W-1:0]  head_id;
		dispatch_t                 d;
		if (it.op == rrd_pkg::OP_ARRIVAL) begin
			if (it.burst != 0)
				ready_push(it.pid, it.burst);
			return;
		end
		if (slice_end == now_time) begin
			if (rq_count != 0) begin
				head_id     = rq_id[rq_head];
				head_rem    = rq_rem[rq_head];
				slice_units = (slice_reg == 0) ? 16'd1 : rrd_pkg::REM_W'(slice_reg);
				granted     = (head_rem < slice_units) ? head_rem : slice_units;
				rq_head = (rq_head + 1 >= RQ_DEPTH) ? 0 : rq_head + 1;
				rq_count--;
				slice_end = now_time + rrd_pkg::TIME_W'(granted);
				pre_id    = head_id;
				pre_rem   = head_rem - granted;
				d.id    = head_id;
				d.start = now_time;
				d.run   = granted[7:0];
				d.ovf   = ovf_flag;
				dispatch_q.push_back(d);
				dispatches_predicted++;
				if (ovf_flag)
					ovf_predicted++;
				ovf_flag = 1'b0;
			end else begin
				slice_end = now_time + 1;
			end
		end
		now_time = now_time + 1;
		if (now_time == slice_end && pre_rem != 0) begin
			ready_push(pre_id, pre_rem);
			pre_id  = '0;
			pre_rem = '0;
		end
	endfunction

	function automatic void note_mismatch(string what, longint unsigned want, longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("dispatch check, %s: expected %0d, got %0d", what, want, got);
	endfunction

	function automatic void add_arrival(input logic [rrd_pkg::ID_W-1:0] pid,
		input logic [rrd_pkg::REM_W-1:0] burst);
		sched_item_t it;
		it.op    = rrd_pkg::OP_ARRIVAL;
		it.pid   = pid;
		it.burst = burst;
		pending.push_back(it);
		if (burst != 0)
			queued_items++;
	endfunction

	function automatic void add_tick();
		sched_item_t it;
		it.op    = rrd_pkg::OP_TICK;
		it.pid   = rrd_pkg::ID_W'($urandom);
		it.burst = rrd_pkg::REM_W'($urandom);
		pending.push_back(it);
		queued_items++;
		tick_items++;
	endfunction

	function automatic logic [rrd_pkg::REM_W-1:0] rand_burst();
		case ($urandom_range(0, 31))
			0:       return rrd_pkg::REM_W'($urandom_range(1, 65535));
			1, 2:    return rrd_pkg::REM_W'($urandom_range(1, 600));
			default: return rrd_pkg::REM_W'($urandom_range(1, 12));
		endcase
	endfunction

	task automatic write_slice(input logic [rrd_pkg::SLICE_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		slice_reg = value;
		slice_writes++;
		cfg_valid <= 1'b0;
	endtask

	// sampled at the falling edge so the driver's updates of this cycle are settled
	task automatic wait_drained();
		do @(negedge clk); while (pending.size() != 0 || s_tvalid || dispatch_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic hold;
		logic nxt_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			hold = s_tvalid && !s_tready;
			if (s_tvalid && s_tready)
				advance_dispatcher(cur_item);
			if (!hold) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() != 0) begin
					cur_item  = pending.pop_front();
					nxt_valid = 1'b1;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				s_tvalid <= nxt_valid;
				if (nxt_valid) begin
					s_tdata <= {cur_item.burst, cur_item.pid};
					s_tuser <= cur_item.op;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		dispatch_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (dispatch_q.size() == 0) begin
					note_mismatch("result with none pending, id", 0, m_tdata[7:0]);
				end else begin
					want = dispatch_q.pop_front();
					results_seen++;
					if (m_tdata[7:0] !== want.id)
						note_mismatch("dispatched_id", want.id, m_tdata[7:0]);
					if (m_tdata[39:8] !== want.start)
						note_mismatch("start_time", want.start, m_tdata[39:8]);
					if (m_tdata[47:40] !== want.run)
						note_mismatch("run_length", want.run, m_tdata[47:40]);
					if (m_tdata[48] !== want.ovf)
						note_mismatch("overflow_seen", want.ovf, m_tdata[48]);
				end
			end
			stall_pos = stall_pos + 1;
			if (stall_pos == 0)
				stall_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0101);
			m_tready <= stall_mask[stall_pos[3:0]];
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", quiet_cycles);
				$display("round_robin_time_slice_dispatcher_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int unsigned                 directed_items;
		int unsigned                 phase;
		int unsigned                 phase_end;
		int unsigned                 kind;
		int unsigned                 n;
		int                          pid;
		logic [rrd_pkg::SLICE_W-1:0] slice_v;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty tick, id zero, minimal and maximal fields, ignored
		// zero burst, exact-slice and slice-plus-one bursts, reset slice
		add_tick();
		add_arrival(8'd0, 16'd3);
		add_arrival(8'd1, 16'd1);
		add_arrival(8'd9, 16'd0);
		add_arrival(8'd255, 16'hffff);
		add_tick();
		add_arrival(8'd2, 16'd5);
		add_arrival(8'd128, 16'd4);
		repeat (16) add_tick();
		directed_items = queued_items;
		wait_drained();

		phase = 0;
		while ((queued_items < directed_items + RANDOM_ITEMS ||
			dispatches_predicted < MIN_DISPATCH) && phase < 40) begin
			case (phase)
				0:       slice_v = 8'd255;
				1:       slice_v = 8'd1;
				2:       slice_v = 8'd0;
				3:       slice_v = 8'd2;
				default: slice_v = rrd_pkg::SLICE_W'($urandom_range(1, 255));
			endcase
			write_slice(slice_v);
			phase_end = queued_items + 100;
			while (queued_items < phase_end) begin
				kind = $urandom_range(0, 11);
				n    = (kind == 0) ? $urandom_range(17, 22) : $urandom_range(0, 3);
				pid  = $urandom_range(1, 40);
				for (int i = 0; i < n; i++) begin
					if (kind == 1) begin
						// noise: any id, any order, some zero bursts
						add_arrival(rrd_pkg::ID_W'($urandom_range(0, 255)),
							($urandom_range(0, 2) == 0) ? 16'd0 : rand_burst());
					end else begin
						add_arrival(rrd_pkg::ID_W'(pid), rand_burst());
						pid = pid + $urandom_range(1, 10);
						if (pid > 255)
							pid = 255;
					end
				end
				repeat ($urandom_range(1, 2)) add_tick();
			end
			wait_drained();
			phase++;
		end

		if (dispatch_q.size() != 0) begin
			$display("%0d dispatches never seen", dispatch_q.size());
			mismatches += dispatch_q.size();
		end
		$display("%0d items (%0d ticks) over %0d slice settings; %0d dispatches checked",
			queued_items, tick_items, slice_writes, results_seen);
		$display("%0d dispatches carried a dropped-push flag", ovf_predicted);
		if (mismatches == 0) begin
			$display("round_robin_time_slice_dispatcher_unit: match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("round_robin_time_slice_dispatcher_unit: mismatch");
		end
		$finish;
	end

endmodule
